@@ rtl/core/gps_movement_detector_macros.svh @@
// Assertion macros shared by the movement detector checker.
`ifndef GPS_MOVEMENT_DETECTOR_MACROS_SVH
`define GPS_MOVEMENT_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GMD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gps_movement_detector check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define GMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gps_movement_detector check failed");

`endif

@@ rtl/core/gmd_pkg.sv @@
// Types, constants and tables of the movement detector.
package gmd_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] DIV_LAST = 5'd1;
    localparam logic [4:0] SQ_LAST  = 5'd30;

    localparam logic signed [35:0] INV_GAIN   = 36'sd326016437;
    localparam logic signed [31:0] PI_Q29     = 32'sd1686629713;
    localparam logic signed [31:0] DIST_SCALE = 32'sd101936000;
    localparam logic signed [31:0] DIV_RECIP  = 32'sd1601279867;  // floor(2^59 / 360e6)
    localparam logic [28:0]        DIST_MAX   = 29'd400000000;
    localparam logic [28:0]        THR_RESET  = 29'd128;

    // angle slots of the trigonometry pass
    localparam logic [1:0] ANG_DLAT = 2'd0;
    localparam logic [1:0] ANG_DLON = 2'd1;
    localparam logic [1:0] ANG_LAT1 = 2'd2;
    localparam logic [1:0] ANG_LAT2 = 2'd3;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_REF     = 2'd1,
        ST_STILL   = 2'd2,
        ST_MOVED   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_BAD, OP_REF, OP_ANG_LOAD, OP_ANG_MUL,
        OP_DIV_INIT, OP_DIV_EST, OP_DIV_MUL, OP_DIV_REM, OP_DIV_STEP,
        OP_ROT_INIT, OP_ROT_STEP, OP_ROT_STORE,
        OP_MUL_CC, OP_NARROW, OP_MUL_T, OP_MUL_SQ, OP_ACC_LOAD, OP_ACC_ADD,
        OP_A_CLAMP, OP_SQ_INIT, OP_SQ_STEP, OP_SQ_STORE, OP_VEC_INIT,
        OP_VEC_STEP, OP_DIST_MUL, OP_DIST_FIN, OP_PUSH
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ANG_LOAD, S_ANG_MUL, S_DIV_INIT, S_DIV_EST,
        S_DIV_MUL, S_DIV_REM, S_DIV,
        S_ROT_INIT, S_ROT, S_ROT_STORE, S_MUL_CC, S_NARROW_CC, S_MUL_T1,
        S_NARROW_T, S_MUL_SQ, S_ACC_LOAD, S_MUL_T2, S_ACC_ADD, S_A_CLAMP,
        S_SQ_INIT, S_SQ, S_SQ_STORE, S_VEC_INIT, S_VEC, S_DIST_MUL,
        S_DIST_FIN, S_DONE
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic [1:0] ang;
        logic       sel;
    } t_cmd;

    typedef struct packed {
        logic fix_bad;
        logic ref_valid;
        logic out_busy;
    } t_dp_stat;

    // arctangent of 2^-i in Q2.29
    function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
        logic signed [35:0] v;
        v = '0;
        if (i < 5'd10) begin
            case (i)
                5'd0:    v = 36'sd421657428;
                5'd1:    v = 36'sd248918915;
                5'd2:    v = 36'sd131521918;
                5'd3:    v = 36'sd66762579;
                5'd4:    v = 36'sd33510843;
                5'd5:    v = 36'sd16771758;
                5'd6:    v = 36'sd8387925;
                5'd7:    v = 36'sd4194219;
                5'd8:    v = 36'sd2097141;
                default: v = 36'sd1048575;
            endcase
        end else if (i <= 5'd29) begin
            v = 36'sd1 <<< (5'd29 - i);
        end
        return v;
    endfunction

endpackage

@@ rtl/core/gmd_ctrl.sv @@
// Sequencer of the movement detector: steps the datapath through one fix.
module gmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  gmd_pkg::t_dp_stat i_stat,
    output gmd_pkg::t_cmd     o_cmd
);
    import gmd_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [1:0] r_ang, n_ang;
    logic       r_sel, n_sel;

    // hold state and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ang   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ang   <= n_ang;
            r_sel   <= n_sel;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_ang      = r_ang;
        n_sel      = r_sel;
        o_s_tready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        o_cmd.ang  = r_ang;
        o_cmd.sel  = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.fix_bad) begin
                    o_cmd.op = OP_BAD;
                    n_state  = S_DONE;
                end else if (!i_stat.ref_valid) begin
                    o_cmd.op = OP_REF;
                    n_state  = S_DONE;
                end else begin
                    n_ang   = ANG_DLAT;
                    n_state = S_ANG_LOAD;
                end
            end
            S_ANG_LOAD: begin
                o_cmd.op = OP_ANG_LOAD;
                n_state  = S_ANG_MUL;
            end
            S_ANG_MUL: begin
                o_cmd.op = OP_ANG_MUL;
                n_state  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_step   = '0;
                n_state  = S_DIV_EST;
            end
            S_DIV_EST: begin
                o_cmd.op = OP_DIV_EST;
                n_state  = S_DIV_MUL;
            end
            S_DIV_MUL: begin
                o_cmd.op = OP_DIV_MUL;
                n_state  = S_DIV_REM;
            end
            S_DIV_REM: begin
                o_cmd.op = OP_DIV_REM;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == DIV_LAST) begin
                    n_state = S_ROT_INIT;
                end
            end
            S_ROT_INIT: begin
                o_cmd.op = OP_ROT_INIT;
                n_step   = '0;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == ROT_LAST) begin
                    n_state = S_ROT_STORE;
                end
            end
            S_ROT_STORE: begin
                o_cmd.op = OP_ROT_STORE;
                if (r_ang == ANG_LAT2) begin
                    n_state = S_MUL_CC;
                end else begin
                    n_ang   = r_ang + 2'd1;
                    n_state = S_ANG_LOAD;
                end
            end
            S_MUL_CC: begin
                o_cmd.op = OP_MUL_CC;
                n_state  = S_NARROW_CC;
            end
            S_NARROW_CC: begin
                o_cmd.op = OP_NARROW;
                n_state  = S_MUL_T1;
            end
            S_MUL_T1: begin
                o_cmd.op = OP_MUL_T;
                n_state  = S_NARROW_T;
            end
            S_NARROW_T: begin
                o_cmd.op = OP_NARROW;
                n_state  = S_MUL_SQ;
            end
            S_MUL_SQ: begin
                o_cmd.op = OP_MUL_SQ;
                n_state  = S_ACC_LOAD;
            end
            S_ACC_LOAD: begin
                o_cmd.op = OP_ACC_LOAD;
                n_state  = S_MUL_T2;
            end
            S_MUL_T2: begin
                o_cmd.op = OP_MUL_T;
                n_state  = S_ACC_ADD;
            end
            S_ACC_ADD: begin
                o_cmd.op = OP_ACC_ADD;
                n_state  = S_A_CLAMP;
            end
            S_A_CLAMP: begin
                o_cmd.op = OP_A_CLAMP;
                n_sel    = 1'b0;
                n_state  = S_SQ_INIT;
            end
            S_SQ_INIT: begin
                o_cmd.op = OP_SQ_INIT;
                n_step   = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == SQ_LAST) begin
                    n_state = S_SQ_STORE;
                end
            end
            S_SQ_STORE: begin
                o_cmd.op = OP_SQ_STORE;
                if (r_sel) begin
                    n_state = S_VEC_INIT;
                end else begin
                    n_sel   = 1'b1;
                    n_state = S_SQ_INIT;
                end
            end
            S_VEC_INIT: begin
                o_cmd.op = OP_VEC_INIT;
                n_step   = '0;
                n_state  = S_VEC;
            end
            S_VEC: begin
                o_cmd.op = OP_VEC_STEP;
                n_step   = r_step + 5'd1;
                if (r_step == ROT_LAST) begin
                    n_state = S_DIST_MUL;
                end
            end
            S_DIST_MUL: begin
                o_cmd.op = OP_DIST_MUL;
                n_state  = S_DIST_FIN;
            end
            S_DIST_FIN: begin
                o_cmd.op = OP_DIST_FIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // wait for a free output register
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/gmd_datapath.sv @@
// Datapath of the movement detector: reference, CORDIC, divider, root, output.
module gmd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmd_pkg::t_cmd     i_cmd,
    output gmd_pkg::t_dp_stat o_stat,
    input  logic [63:0]       i_s_tdata,   // lat_udeg[27:0], lon_udeg[56:28], zero
    input  logic              i_s_tuser,   // fix_present
    input  logic              i_cfg_valid,
    input  logic [28:0]       i_cfg_data,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // distance[28:0], zero
    output logic [1:0]        o_m_tuser    // status
);
    import gmd_pkg::*;

    localparam logic signed [31:0] FULL_S = 32'sd720000000;
    localparam logic signed [31:0] HALF_S = 32'sd360000000;
    localparam logic signed [31:0] QTR_S  = 32'sd180000000;
    localparam logic [30:0]        DIV_D  = 31'd360000000;
    localparam logic [30:0]        ONE_Q30 = 31'h40000000;

    // input fix and reference
    logic               r_fix;
    logic signed [27:0] r_lat, r_ref_lat;
    logic signed [28:0] r_lon, r_ref_lon;
    logic               r_ref_valid;
    logic [28:0]        r_thr;

    // angle conversion and CORDIC
    logic [27:0]        r_mag;
    logic               r_negc, r_negz;
    logic [58:0]        r_num;
    logic [29:0]        r_quo;
    logic signed [35:0] r_x, r_y, r_z;
    logic signed [31:0] r_sdlat, r_sdlon, r_c1, r_c2, r_tmp;
    logic signed [63:0] r_prod, r_acc;
    logic [30:0]        r_a, r_s, r_w;
    logic [60:0]        r_v;
    logic [61:0]        r_res;

    // result and output registers
    t_status            r_res_stat, r_out_stat;
    logic [28:0]        r_res_dist, r_out_dist;
    logic               r_out_valid;

    logic signed [31:0] w_h, w_r, w_f, w_abs;
    logic               w_negc;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [35:0] w_dx, w_dy, w_at, w_q, w_cx;
    logic               w_pos;
    logic signed [63:0] w_n, w_nr, w_as, w_d;
    logic               w_ge;
    logic [61:0]        w_bit, w_rb;
    logic               w_sq_ge;
    logic [30:0]        w_v;
    logic [28:0]        w_dsat;

    assign o_stat.fix_bad   = !r_fix || (r_lat == '0 && r_lon == '0);
    assign o_stat.ref_valid = r_ref_valid;
    assign o_stat.out_busy  = r_out_valid && !i_m_tready;

    // select the angle and reduce it to a folded magnitude
    always_comb begin
        case (i_cmd.ang)
            ANG_DLAT: w_h = 32'(r_lat) - 32'(r_ref_lat);
            ANG_DLON: w_h = 32'(r_lon) - 32'(r_ref_lon);
            ANG_LAT1: w_h = $signed({{3{r_ref_lat[27]}}, r_ref_lat, 1'b0});
            default:  w_h = $signed({{3{r_lat[27]}}, r_lat, 1'b0});
        endcase
        if (w_h >= HALF_S) begin
            w_r = w_h - FULL_S;
        end else if (w_h < -HALF_S) begin
            w_r = w_h + FULL_S;
        end else begin
            w_r = w_h;
        end
        w_negc = 1'b1;
        if (w_r > QTR_S) begin
            w_f = HALF_S - w_r;
        end else if (w_r < -QTR_S) begin
            w_f = -HALF_S - w_r;
        end else begin
            w_f    = w_r;
            w_negc = 1'b0;
        end
        w_abs = w_f[31] ? -w_f : w_f;
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            OP_ANG_MUL: begin
                w_mul_a = $signed({4'b0, r_mag});
                w_mul_b = PI_Q29;
            end
            OP_DIV_EST: begin
                w_mul_a = $signed({1'b0, r_num[58:28]});
                w_mul_b = DIV_RECIP;
            end
            OP_DIV_MUL: begin
                w_mul_a = $signed({2'b0, r_prod[60:31]});
                w_mul_b = $signed({1'b0, DIV_D});
            end
            OP_MUL_CC: begin
                w_mul_a = r_c1;
                w_mul_b = r_c2;
            end
            OP_MUL_T: begin
                w_mul_a = r_tmp;
                w_mul_b = r_sdlon;
            end
            OP_MUL_SQ: begin
                w_mul_a = r_sdlat;
                w_mul_b = r_sdlat;
            end
            OP_DIST_MUL: begin
                w_mul_a = r_z[35] ? 32'sd0 : $signed(r_z[31:0]);
                w_mul_b = DIST_SCALE;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // CORDIC micro-rotation, rotation or vectoring by the command
    assign w_dx  = r_y >>> i_cmd.step;
    assign w_dy  = r_x >>> i_cmd.step;
    assign w_at  = atan_entry(i_cmd.step);
    assign w_pos = (i_cmd.op == OP_ROT_STEP) ? !r_z[35] : r_y[35];
    assign w_q   = $signed({6'b0, r_quo});
    assign w_cx  = r_negc ? -r_x : r_x;

    // half-turn division: reciprocal estimate, then up to two corrections
    assign w_n  = r_prod + 64'sd180000000;
    assign w_ge = r_num >= {28'b0, DIV_D};

    // rounding and clamping of the products
    assign w_nr   = (r_prod + 64'sd268435456) >>> 29;
    assign w_as   = (r_acc + 64'sd134217728) >>> 28;
    assign w_d    = (r_prod + 64'sd134217728) >>> 28;
    assign w_dsat = (w_d > 64'sd400000000) ? DIST_MAX : w_d[28:0];

    // square root step, one result bit per step of the remainder
    assign w_bit   = 62'd1 << {(5'd30 - i_cmd.step), 1'b0};
    assign w_rb    = r_res + w_bit;
    assign w_sq_ge = {1'b0, r_v} >= w_rb;
    assign w_v     = i_cmd.sel ? (ONE_Q30 - r_a) : r_a;

    // control state: reference, threshold, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_valid <= 1'b0;
            r_ref_lat   <= '0;
            r_ref_lon   <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (i_cmd.op == OP_REF) begin
                r_ref_valid <= 1'b1;
                r_ref_lat   <= r_lat;
                r_ref_lon   <= r_lon;
            end
            if (i_cmd.op == OP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, advanced by command
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_fix <= i_s_tuser;
                r_lat <= $signed(i_s_tdata[27:0]);
                r_lon <= $signed(i_s_tdata[56:28]);
            end
            OP_BAD: begin
                r_res_stat <= ST_INVALID;
                r_res_dist <= '0;
            end
            OP_REF: begin
                r_res_stat <= ST_REF;
                r_res_dist <= '0;
            end
            OP_ANG_LOAD: begin
                r_mag  <= w_abs[27:0];
                r_negz <= w_f[31];
                r_negc <= w_negc;
            end
            OP_ANG_MUL, OP_DIV_EST, OP_MUL_CC, OP_MUL_T, OP_MUL_SQ, OP_DIST_MUL: begin
                r_prod <= w_prod;
            end
            OP_DIV_INIT: begin
                r_num <= w_n[58:0];
            end
            OP_DIV_MUL: begin
                r_quo  <= r_prod[60:31];
                r_prod <= w_prod;
            end
            OP_DIV_REM: begin
                r_num <= r_num - r_prod[58:0];
            end
            OP_DIV_STEP: begin
                if (w_ge) begin
                    r_num <= r_num - {28'b0, DIV_D};
                    r_quo <= r_quo + 30'd1;
                end
            end
            OP_ROT_INIT: begin
                r_x <= INV_GAIN;
                r_y <= '0;
                r_z <= r_negz ? -w_q : w_q;
            end
            OP_ROT_STEP, OP_VEC_STEP: begin
                if (w_pos) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
            end
            OP_ROT_STORE: begin
                case (i_cmd.ang)
                    ANG_DLAT: r_sdlat <= $signed(r_y[31:0]);
                    ANG_DLON: r_sdlon <= $signed(r_y[31:0]);
                    ANG_LAT1: r_c1    <= $signed(w_cx[31:0]);
                    default:  r_c2    <= $signed(w_cx[31:0]);
                endcase
            end
            OP_NARROW: begin
                r_tmp <= $signed(w_nr[31:0]);
            end
            OP_ACC_LOAD: begin
                r_acc <= r_prod;
            end
            OP_ACC_ADD: begin
                r_acc <= r_acc + r_prod;
            end
            OP_A_CLAMP: begin
                if (w_as[63]) begin
                    r_a <= '0;
                end else if (w_as > 64'sd1073741824) begin
                    r_a <= ONE_Q30;
                end else begin
                    r_a <= w_as[30:0];
                end
            end
            OP_SQ_INIT: begin
                r_v   <= {w_v, 30'b0};
                r_res <= '0;
            end
            OP_SQ_STEP: begin
                if (w_sq_ge) begin
                    r_v   <= 61'({1'b0, r_v} - w_rb);
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            OP_SQ_STORE: begin
                if (i_cmd.sel) begin
                    r_w <= r_res[30:0];
                end else begin
                    r_s <= r_res[30:0];
                end
            end
            OP_VEC_INIT: begin
                r_x <= $signed({5'b0, r_w});
                r_y <= $signed({5'b0, r_s});
                r_z <= '0;
            end
            OP_DIST_FIN: begin
                r_res_dist <= w_dsat;
                r_res_stat <= (w_dsat > r_thr) ? ST_MOVED : ST_STILL;
            end
            OP_PUSH: begin
                r_out_stat <= r_res_stat;
                r_out_dist <= r_res_dist;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b0, r_out_dist};
    assign o_m_tuser  = r_out_stat;

endmodule

@@ rtl/core/gps_movement_detector.sv @@
// A missing fix, a fix at the origin or the reference fix skips the arithmetic and goes to the output.
// A distance fix passes through the shared CORDIC, run four times for the angles and once
// for atan2, and through the two square roots.
// Throughput: one fix at a time; the next is taken while a result waits in the output.
// Reset (i_rst_n low, synchronous) clears the reference, sets the threshold to 128 and
// empties the output register.
module gps_movement_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // lat_udeg[27:0], lon_udeg[56:28], zero
    input  logic        i_s_tuser,   // fix_present
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // distance[28:0], zero
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [28:0] i_cfg_data   // move_threshold
);
    import gmd_pkg::*;

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    // threshold writes are always taken
    assign o_cfg_ready = 1'b1;

    gmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gmd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

@@ rtl/core/gmd_checker.sv @@
// Port checker of the movement detector and its bind to the top level.
`include "gps_movement_detector_macros.svh"

module gmd_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [63:0] i_s_tdata,   // lat_udeg[27:0], lon_udeg[56:28], zero
    input logic        i_s_tuser,   // fix_present
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,   // distance[28:0], zero
    input logic [1:0]  o_m_tuser,   // status
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [28:0] i_cfg_data
);
    import gmd_pkg::*;

    // hold a stalled result
    `GMD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // one fix at a time: no transfer right after a transfer
    `GMD_ASSERT_NEXT(a_one_fix, i_s_tvalid && o_s_tready, !o_s_tready)

    // invalid and reference results carry no distance
    `GMD_ASSERT_IMPL(a_zero_dist, o_m_tvalid && (o_m_tuser < ST_STILL), o_m_tdata == 32'd0)

    // distance stays within saturation
    `GMD_ASSERT_IMPL(a_dist_max, o_m_tvalid, o_m_tdata <= 32'd400000000)

endmodule

bind gps_movement_detector gmd_port_checker u_gmd_checker (.*);
